### sv/smmc_pkg.sv
// ---------------------------------------------------------------------------
// smmc_pkg: shared types and constants for the sensor min/max calibrator
// Word layouts, phase codes, register indexes and lane control bundle.
// ---------------------------------------------------------------------------
package smmc_pkg;

	localparam int SENSOR_COUNT = 5;
	localparam int DATA_W       = 16;
	localparam int PHASE_W      = 3;
	localparam int CFG_IDX_W    = 1;

	localparam logic [DATA_W-1:0] DATA_MAX          = {DATA_W{1'b1}};
	localparam logic [DATA_W-1:0] WAIT_TICKS_RST    = 16'd100;
	localparam logic [DATA_W-1:0] SAMPLE_TARGET_RST = 16'd500;

	// sequencer phases
	typedef enum logic [PHASE_W-1:0] {
		PH_WAIT_DARK     = 3'd0,
		PH_SAMPLE_DARK   = 3'd1,
		PH_WAIT_BRIGHT   = 3'd2,
		PH_SAMPLE_BRIGHT = 3'd3,
		PH_DONE          = 3'd4
	} phase_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAIT_TICKS    = 1'b0,
		REG_SAMPLE_TARGET = 1'b1
	} cfg_reg_t;

	// one tick: readings of all sensors
	typedef struct packed {
		logic [DATA_W-1:0] sample_0;
		logic [DATA_W-1:0] sample_1;
		logic [DATA_W-1:0] sample_2;
		logic [DATA_W-1:0] sample_3;
		logic [DATA_W-1:0] sample_4;
	} sample_word_t;

	// one result: phase and all tracked extremes
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [DATA_W-1:0]  low_0;
		logic [DATA_W-1:0]  low_1;
		logic [DATA_W-1:0]  low_2;
		logic [DATA_W-1:0]  low_3;
		logic [DATA_W-1:0]  low_4;
		logic [DATA_W-1:0]  high_0;
		logic [DATA_W-1:0]  high_1;
		logic [DATA_W-1:0]  high_2;
		logic [DATA_W-1:0]  high_3;
		logic [DATA_W-1:0]  high_4;
	} result_word_t;

	// per-tick commands from sequencer to every lane
	typedef struct packed {
		logic clr_min;
		logic clr_max;
		logic upd_min;
		logic upd_max;
	} lane_ctl_t;

endpackage

### sv/smmc_lane.sv
// ---------------------------------------------------------------------------
// smmc_lane: one sensor lane
// Holds the running minimum and maximum of one sensor and applies the
// clear / compare-and-select commands of the sequencer.
// ---------------------------------------------------------------------------
module smmc_lane
	import smmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  lane_ctl_t         ctl,
	input  logic [DATA_W-1:0] sample,
	output logic [DATA_W-1:0] low_nxt,
	output logic [DATA_W-1:0] high_nxt
);

	logic [DATA_W-1:0] low_q;
	logic [DATA_W-1:0] high_q;

	// next extremes for this tick
	always_comb begin
		low_nxt = low_q;
		if (ctl.clr_min) begin
			low_nxt = DATA_MAX;
		end else if (ctl.upd_min && (sample < low_q)) begin
			low_nxt = sample;
		end

		high_nxt = high_q;
		if (ctl.clr_max) begin
			high_nxt = '0;
		end else if (ctl.upd_max && (sample > high_q)) begin
			high_nxt = sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= DATA_MAX;
			high_q <= '0;
		end else begin
			low_q  <= low_nxt;
			high_q <= high_nxt;
		end
	end

endmodule

### sv/smmc_seq.sv
// ---------------------------------------------------------------------------
// smmc_seq: calibration sequencer
// Five-phase one-pass sequencer with wait and sample counters, plus the
// two configuration registers. Issues lane commands for each accepted tick.
// ---------------------------------------------------------------------------
module smmc_seq
	import smmc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	output logic [PHASE_W-1:0]   phase_nxt,
	output lane_ctl_t            ctl
);

	phase_t            phase_q, phase_d;
	logic [DATA_W-1:0] wait_q, wait_d;
	logic [DATA_W-1:0] taken_q, taken_d;
	logic [DATA_W-1:0] wait_ticks_q;
	logic [DATA_W-1:0] sample_target_q;
	logic [DATA_W-1:0] wait_inc;
	logic              more_samples;

	// saturating tick count and sample budget check
	assign wait_inc     = (wait_q == DATA_MAX) ? wait_q : wait_q + 1'b1;
	assign more_samples = taken_q < sample_target_q;

	// next state for one accepted tick
	always_comb begin
		phase_d = phase_q;
		wait_d  = wait_q;
		taken_d = taken_q;
		ctl     = '0;
		if (take) begin
			case (phase_q)
				PH_WAIT_DARK: begin
					wait_d = wait_inc;
					if (wait_inc >= wait_ticks_q) begin
						ctl.clr_min = 1'b1;
						taken_d     = '0;
						phase_d     = PH_SAMPLE_DARK;
					end
				end
				PH_SAMPLE_DARK: begin
					if (more_samples) begin
						ctl.upd_min = 1'b1;
						taken_d     = taken_q + 1'b1;
					end else begin
						wait_d  = '0;
						phase_d = PH_WAIT_BRIGHT;
					end
				end
				PH_WAIT_BRIGHT: begin
					wait_d = wait_inc;
					if (wait_inc >= wait_ticks_q) begin
						ctl.clr_max = 1'b1;
						taken_d     = '0;
						phase_d     = PH_SAMPLE_BRIGHT;
					end
				end
				PH_SAMPLE_BRIGHT: begin
					if (more_samples) begin
						ctl.upd_max = 1'b1;
						taken_d     = taken_q + 1'b1;
					end else begin
						phase_d = PH_DONE;
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end
	end

	assign phase_nxt = phase_d;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_DARK;
			wait_q  <= '0;
			taken_q <= '0;
		end else begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			taken_q <= taken_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_ticks_q    <= WAIT_TICKS_RST;
			sample_target_q <= SAMPLE_TARGET_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_WAIT_TICKS:    wait_ticks_q    <= cfg_data;
				REG_SAMPLE_TARGET: sample_target_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// phase moves only on an accepted tick
	a_phase_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(phase_q))
		else $error("phase changed without a tick");

	// one pass: phase never goes back
	a_phase_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (phase_q >= $past(phase_q)))
		else $error("phase went backward");

	// a lane is never cleared and updated on the same tick
	a_ctl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!((ctl.clr_min || ctl.clr_max) && (ctl.upd_min || ctl.upd_max)))
		else $error("clear and update issued together");

endmodule

### sv/sensor_min_max_calibrator.sv
// Output: each result word is registered, in the output register or, while
// that is stalled, in the skid entry. Throughput: one tick word per cycle
// while the skid is empty; sequencer and lane registers update in the accept
// cycle, and the two-entry output keeps input accepted while a result waits.
// Reset: phase to wait dark, counters to zero, minima all ones, maxima zero,
// wait_ticks 100, sample_target 500, output empty.
// ---------------------------------------------------------------------------
// sensor_min_max_calibrator: five-sensor min/max calibration block
// Sequencer plus one compare-and-select lane per sensor; lane results are
// merged with the phase into one result word per tick.
// ---------------------------------------------------------------------------
module sensor_min_max_calibrator
	import smmc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  sample_word_t         sample_word,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_word_t         result_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	logic               in_fire;
	logic               out_fire;
	logic [PHASE_W-1:0] phase_nxt;
	lane_ctl_t          ctl;
	logic [DATA_W-1:0]  samples  [SENSOR_COUNT];
	logic [DATA_W-1:0]  low_nxt  [SENSOR_COUNT];
	logic [DATA_W-1:0]  high_nxt [SENSOR_COUNT];
	result_word_t       merged;

	logic               out_valid_q;
	result_word_t       out_word_q;
	logic               skid_valid_q;
	result_word_t       skid_word_q;

	assign cfg_ready    = 1'b1;
	assign sample_ready = !skid_valid_q;
	assign in_fire      = sample_valid && sample_ready;
	assign out_fire     = out_valid_q && result_ready;

	// split the tick word across lanes
	assign samples[0] = sample_word.sample_0;
	assign samples[1] = sample_word.sample_1;
	assign samples[2] = sample_word.sample_2;
	assign samples[3] = sample_word.sample_3;
	assign samples[4] = sample_word.sample_4;

	smmc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (in_fire),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.phase_nxt (phase_nxt),
		.ctl       (ctl)
	);

	for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
		smmc_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.sample   (samples[i]),
			.low_nxt  (low_nxt[i]),
			.high_nxt (high_nxt[i])
		);
	end

	// merge lane results with the phase
	always_comb begin
		merged.phase  = phase_nxt;
		merged.low_0  = low_nxt[0];
		merged.low_1  = low_nxt[1];
		merged.low_2  = low_nxt[2];
		merged.low_3  = low_nxt[3];
		merged.low_4  = low_nxt[4];
		merged.high_0 = high_nxt[0];
		merged.high_1 = high_nxt[1];
		merged.high_2 = high_nxt[2];
		merged.high_3 = high_nxt[3];
		merged.high_4 = high_nxt[4];
	end

	// output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_fire || !out_valid_q) begin
				out_valid_q  <= skid_valid_q || in_fire;
				skid_valid_q <= 1'b0;
			end else if (in_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire || !out_valid_q) begin
			out_word_q <= skid_valid_q ? skid_word_q : merged;
		end
		if (in_fire && out_valid_q && !out_fire) begin
			skid_word_q <= merged;
		end
	end

	assign result_valid = out_valid_q;
	assign result_word  = out_word_q;

	// skid only fills behind a full output register
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a word ahead of the output");

	// a tick arriving against a stalled output lands in the skid
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && out_valid_q && !result_ready) |=> skid_valid_q)
		else $error("tick result dropped on stall");

	// draining the last word with nothing behind it empties the output
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !skid_valid_q && !in_fire) |=> !out_valid_q)
		else $error("result repeated after drain");

endmodule
